// File: rtl/xmodem_checksum_receiver_defines.svh
// Assertion macros used by the checker of the receiver.
`ifndef XMODEM_CHECKSUM_RECEIVER_DEFINES_SVH
`define XMODEM_CHECKSUM_RECEIVER_DEFINES_SVH

// Checked only while out of reset.
`define XMCR_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("xmcr assertion failed");

// Checked on every edge, reset included.
`define XMCR_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("xmcr assertion failed during reset");

`endif

// File: rtl/xmcr_pkg.sv
package xmcr_pkg;

  // Protocol characters.
  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_EOT = 8'h04;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 1'b1;
  localparam int CFG_DATA_W = 16;

  localparam logic [15:0] TIMEOUT_RESET = 16'd4000;

  // Command queue between front and back.
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic       is_tick;
    logic       is_soh;
    logic       is_eot;
    logic [7:0] data;
  } cmd_t;

  typedef enum logic [4:0] {
    PH_HEADER  = 5'b00001,
    PH_NUMBER  = 5'b00010,
    PH_INVERSE = 5'b00100,
    PH_DATA    = 5'b01000,
    PH_SUM     = 5'b10000
  } phase_t;

  typedef struct packed {
    logic        reply_valid;
    logic [7:0]  reply_byte;
    logic        store_valid;
    logic [14:0] store_address;
    logic [7:0]  store_data;
    logic        done_res;
    logic [14:0] done_length;
    logic        overflow_error;
  } res_t;

endpackage

// File: rtl/xmcr_front.sv
module xmcr_front
  import xmcr_pkg::*;
(
  input  logic       in_valid,
  input  logic       in_func,
  input  logic [7:0] in_rx_byte,
  output logic       in_stall,
  input  logic       q_full,
  output logic       push,
  output cmd_t       push_cmd
);

  // Accept whenever the queue has room; decode the header characters here
  // so the back end sees them as flags.
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_cmd.is_tick = in_func;
    push_cmd.is_soh  = !in_func && (in_rx_byte == CH_SOH);
    push_cmd.is_eot  = !in_func && (in_rx_byte == CH_EOT);
    push_cmd.data    = in_rx_byte;
  end

endmodule

// File: rtl/xmcr_queue.sv
module xmcr_queue
  import xmcr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign full       = (count_r == QCNT_W'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// File: rtl/xmcr_back.sv
module xmcr_back
  import xmcr_pkg::*;
#(
  parameter int PAYLOAD_BYTES = 128
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  head_valid,
  input  cmd_t                  head_cmd,
  output logic                  pop,
  input  logic                  out_stall,
  output logic                  out_valid,
  output res_t                  out_res
);

  localparam int POS_W = 9 + $clog2(PAYLOAD_BYTES + 1);
  localparam int CMP_W = (POS_W > 17) ? POS_W : 17;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  block_r, block_nxt;
  logic [7:0]  index_r, index_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [15:0] idle_r, idle_nxt;
  logic [15:0] buf_len_r;
  logic [15:0] timeout_r;
  logic        out_valid_r;
  res_t        out_res_r;
  res_t        res;

  logic [7:0]       block_m1;
  logic [POS_W-1:0] base;
  logic [POS_W-1:0] pos;
  logic [7:0]       index_inc;
  logic [15:0]      idle_inc;
  logic             overrun;
  logic             restart;

  assign pop       = head_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  assign block_m1  = block_r - 8'd1;
  assign base      = POS_W'(block_m1) * POS_W'(PAYLOAD_BYTES);
  assign pos       = base + POS_W'(index_r);
  assign index_inc = index_r + 8'd1;
  assign idle_inc  = idle_r + 16'd1;
  assign overrun   = (block_r == 8'd0)
                  || (CMP_W'(pos) >= CMP_W'(buf_len_r))
                  || (CMP_W'(pos) >= CMP_W'(32768));

  always_comb begin
    phase_nxt = phase_r;
    block_nxt = block_r;
    index_nxt = index_r;
    sum_nxt   = sum_r;
    idle_nxt  = idle_r;
    res       = '0;
    restart   = 1'b0;

    if (pop) begin
      if (head_cmd.is_tick) begin
        if (idle_inc >= timeout_r) begin
          res.reply_valid = 1'b1;
          res.reply_byte  = CH_NAK;
          idle_nxt        = '0;
        end else begin
          idle_nxt = idle_inc;
        end
      end else begin
        idle_nxt = '0;
        unique case (phase_r)
          PH_HEADER: begin
            if (head_cmd.is_eot) begin
              res.reply_valid = 1'b1;
              res.reply_byte  = CH_ACK;
              res.done_res    = 1'b1;
              res.done_length = 15'(base);
              block_nxt       = 8'd1;
            end else if (head_cmd.is_soh) begin
              phase_nxt = PH_NUMBER;
              sum_nxt   = '0;
            end else begin
              // Stray byte: retry the current block only.
              res.reply_valid = 1'b1;
              res.reply_byte  = CH_NAK;
              phase_nxt       = PH_HEADER;
              sum_nxt         = '0;
            end
          end
          PH_NUMBER: begin
            if (head_cmd.data == block_r) begin
              phase_nxt = PH_INVERSE;
            end else begin
              restart = 1'b1;
            end
          end
          PH_INVERSE: begin
            if (head_cmd.data == ~block_r) begin
              phase_nxt = PH_DATA;
              index_nxt = '0;
            end else begin
              restart = 1'b1;
            end
          end
          PH_DATA: begin
            if (overrun) begin
              restart            = 1'b1;
              res.overflow_error = 1'b1;
            end else begin
              res.store_valid   = 1'b1;
              res.store_address = 15'(pos);
              res.store_data    = head_cmd.data;
              sum_nxt           = sum_r + head_cmd.data;
              index_nxt         = index_inc;
              if (index_inc == 8'(PAYLOAD_BYTES)) begin
                phase_nxt = PH_SUM;
              end
            end
          end
          PH_SUM: begin
            if (head_cmd.data != sum_r) begin
              restart = 1'b1;
            end else begin
              res.reply_valid = 1'b1;
              res.reply_byte  = CH_ACK;
              block_nxt       = block_r + 8'd1;
              phase_nxt       = PH_HEADER;
            end
          end
          default: begin
            restart = 1'b1;
          end
        endcase
        if (restart) begin
          res.reply_valid = 1'b1;
          res.reply_byte  = CH_NAK;
          phase_nxt       = PH_HEADER;
          block_nxt       = 8'd1;
          index_nxt       = '0;
          sum_nxt         = '0;
        end
      end
    end

    // Writing the buffer length starts a new transfer at block 1.
    if (cfg_we && (cfg_index == REG_BUFFER_LENGTH)) begin
      block_nxt = 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      block_r     <= 8'd1;
      index_r     <= '0;
      sum_r       <= '0;
      idle_r      <= '0;
      buf_len_r   <= '0;
      timeout_r   <= TIMEOUT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      block_r <= block_nxt;
      index_r <= index_nxt;
      sum_r   <= sum_nxt;
      idle_r  <= idle_nxt;
      if (cfg_we && (cfg_index == REG_BUFFER_LENGTH)) begin
        buf_len_r <= cfg_wdata;
      end
      if (cfg_we && (cfg_index == REG_TIMEOUT_TICKS)) begin
        timeout_r <= cfg_wdata;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_res_r <= res;
    end
  end

endmodule

// File: rtl/xmodem_checksum_receiver.sv
// XMODEM receiver with an 8-bit additive checksum.
// Input channel (in_valid / in_stall): each transfer carries either one byte
// from the serial line (in_func = 0, in_rx_byte) or one timer tick
// (in_func = 1). Every accepted item yields exactly one result transfer on the
// output channel (out_valid / out_stall), whose fields say whether to send a
// reply byte (ACK or NAK), write a data byte to the buffer, report the end of
// the transfer with its length, or flag a buffer overrun.
// The configuration port (cfg_we, cfg_index, cfg_wdata) sets the buffer
// length (index 0, also restarts at block 1) and the timeout in ticks
// (index 1); write it only while no item is in flight.
// Each accepted item is decoded by the front end, written into a two-entry
// command queue, executed by the protocol engine when it reaches the queue
// head, and its result is registered onto the out_ ports.
// Throughput: one item per cycle while results are not stalled.
// When the receiver of results stalls, the held result stays stable, the
// queue keeps absorbing up to two more items, and only then in_stall rises.
// Synchronous reset (rst_n low) empties the queue, drops any pending result,
// returns to waiting for a block header at block 1, clears the buffer length
// and sets the timeout to 4000 ticks.
module xmodem_checksum_receiver
  import xmcr_pkg::*;
#(
  parameter int PAYLOAD_BYTES = 128
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_func,
  input  logic [7:0]            in_rx_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_reply_valid,
  output logic [7:0]            out_reply_byte,
  output logic                  out_store_valid,
  output logic [14:0]           out_store_address,
  output logic [7:0]            out_store_data,
  output logic                  out_done_res,
  output logic [14:0]           out_done_length,
  output logic                  out_overflow_error
);

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;
  res_t res;

  // Front end: accepts items and decodes the header characters.
  xmcr_front u_front (
    .in_valid   (in_valid),
    .in_func    (in_func),
    .in_rx_byte (in_rx_byte),
    .in_stall   (in_stall),
    .q_full     (q_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  // Short queue that lets the front keep accepting while a result waits.
  xmcr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // Back end: protocol state, timeout counter and the output register.
  xmcr_back #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_res    (res)
  );

  assign out_reply_valid    = res.reply_valid;
  assign out_reply_byte     = res.reply_byte;
  assign out_store_valid    = res.store_valid;
  assign out_store_address  = res.store_address;
  assign out_store_data     = res.store_data;
  assign out_done_res       = res.done_res;
  assign out_done_length    = res.done_length;
  assign out_overflow_error = res.overflow_error;

endmodule

// File: rtl/xmcr_checker.sv
`include "xmodem_checksum_receiver_defines.svh"

module xmcr_checker
  import xmcr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_reply_valid,
  input logic [7:0]  out_reply_byte,
  input logic        out_store_valid,
  input logic [14:0] out_store_address,
  input logic        out_done_res,
  input logic        out_overflow_error
);

  // A stalled result stays presented with the same store offset and reply.
  property p_stalled_result_holds;
    out_valid && out_stall |=>
      out_valid && $stable(out_store_address) && $stable(out_reply_byte);
  endproperty

  // Replies are only ever ACK or NAK.
  property p_reply_code;
    out_valid && out_reply_valid |->
      out_reply_byte == CH_ACK || out_reply_byte == CH_NAK;
  endproperty

  // End of transfer is always acknowledged.
  property p_done_acked;
    out_valid && out_done_res |-> out_reply_valid && out_reply_byte == CH_ACK;
  endproperty

  // An overrun is answered with NAK and writes nothing.
  property p_overflow_nak;
    out_valid && out_overflow_error |-> out_reply_byte == CH_NAK && !out_store_valid;
  endproperty

  // A pending result is dropped by reset.
  `XMCR_ASSERT_ALWAYS(a_reset_clears_result, clk, !rst_n |=> !out_valid)

  `XMCR_ASSERT(a_stalled_result_holds, clk, rst_n, p_stalled_result_holds)

  `XMCR_ASSERT(a_reply_code, clk, rst_n, p_reply_code)

  `XMCR_ASSERT(a_done_acked, clk, rst_n, p_done_acked)

  `XMCR_ASSERT(a_overflow_nak, clk, rst_n, p_overflow_nak)

endmodule

bind xmodem_checksum_receiver xmcr_checker u_xmcr_checker (.*);
